@@ hdl/sftx_pkg.sv @@
package sftx_pkg;

	localparam logic [12:0] MAX_MESSAGE   = 13'd4096;
	localparam logic [12:0] SEGMENT_BYTES = 13'd254;

	localparam logic [7:0] SYN_BYTE     = 8'd22;
	localparam logic [7:0] TYPE_BYTE    = 8'h54;
	localparam logic [7:0] STX_BYTE     = 8'd2;
	localparam logic [7:0] DIR_BYTE     = 8'h30;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] ENQ_CODE     = 8'd5;
	localparam logic [7:0] EOT_CODE     = 8'd4;
	localparam logic [7:0] ACK_CODE     = 8'd6;
	localparam logic [7:0] NACK_CODE    = 8'd21;
	localparam logic [7:0] CHECK_ZERO   = 8'h00;
	localparam logic [7:0] CHECK_ONES   = 8'hFF;
	localparam logic [7:0] CHECK_SUBST  = 8'h01;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam logic [QPTR_W:0] QCNT_FULL = QUEUE_DEPTH[QPTR_W:0];

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_DATA  = 2'd1,
		ACT_CTRL  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_ENQ  = 2'd0,
		KIND_EOT  = 2'd1,
		KIND_ACK  = 2'd2,
		KIND_NACK = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_DATA,
		ST_MIDCHK,
		ST_SYN,
		ST_TYPE,
		ST_STX,
		ST_DIR,
		ST_LEN,
		ST_NL,
		ST_FINCHK,
		ST_CSYN,
		ST_CTYPE,
		ST_CODE,
		ST_CDIR
	} step_t;

	typedef struct packed {
		logic [7:0]  left;
		logic        last_seg;
		logic [12:0] rem;
		logic [7:0]  len;
	} seg_t;

	typedef struct packed {
		logic       is_ctrl;
		logic       has_data;
		logic       mid_chk;
		logic       close;
		logic [7:0] data;
		logic [7:0] mid_val;
		logic [7:0] len;
		logic [7:0] fin_chk;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] block_check(input logic [7:0] x);
		if (x == CHECK_ZERO || x == CHECK_ONES)
			return CHECK_SUBST;
		return x;
	endfunction

	function automatic logic [7:0] ctrl_code(input logic [1:0] k);
		logic [7:0] c;
		case (kind_t'(k))
			KIND_ENQ: c = ENQ_CODE;
			KIND_EOT: c = EOT_CODE;
			KIND_ACK: c = ACK_CODE;
			default:  c = NACK_CODE;
		endcase
		return c;
	endfunction

	function automatic seg_t start_seg(input logic [12:0] rem);
		seg_t s;
		if (rem < SEGMENT_BYTES) begin
			s.left     = rem[7:0];
			s.last_seg = 1'b1;
			s.rem      = '0;
			s.len      = rem[7:0] + 8'd1;
		end else begin
			s.left     = SEGMENT_BYTES[7:0];
			s.last_seg = 1'b0;
			s.rem      = rem - SEGMENT_BYTES;
			s.len      = SEGMENT_BYTES[7:0];
		end
		return s;
	endfunction

endpackage

@@ hdl/sync_frame_transmitter_xor_bce.sv @@
// channel   valid      stall      payload
// request   req_valid  req_stall  action, msg_length, data_byte, control_kind
// line      tx_valid   tx_stall   line_byte, frame_end, run_last
//
// one line byte per cycle while tx_stall is low and a job is queued; a request
// causes 1 to 9 line bytes, or none
// the byte sequencer sets the rate; a four-entry job queue lets the front
// take data requests back to back while a header is still going out
// req_stall rises only when the job queue is full
// arst_n clears the message state, the queue and the output valid

module sync_frame_transmitter_xor_bce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [12:0] msg_length,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  control_kind,
	output logic        tx_valid,
	input  logic        tx_stall,
	output logic [7:0]  line_byte,
	output logic        frame_end,
	output logic        run_last
);
	import sftx_pkg::*;

	q_stat_t q_stat;
	job_t    job;
	job_t    head;
	logic    push;
	logic    pop;

	sftx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.msg_length   (msg_length),
		.data_byte    (data_byte),
		.control_kind (control_kind),
		.q_stat       (q_stat),
		.push         (push),
		.job          (job)
	);

	sftx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job),
		.pop     (pop),
		.job_out (head),
		.q_stat  (q_stat)
	);

	sftx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.line_byte (line_byte),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("job pushed into a full queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_stat.empty) |=> !q_stat.empty)
		else $error("pushed job lost");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !tx_valid) |=> !tx_valid)
		else $error("line byte without a queued job");

	a_check_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && frame_end) |-> (line_byte != CHECK_ZERO && line_byte != CHECK_ONES))
		else $error("frame closed with a forbidden byte");

endmodule

@@ hdl/sftx_front.sv @@
module sftx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        action,
	input  logic [12:0]       msg_length,
	input  logic [7:0]        data_byte,
	input  logic [1:0]        control_kind,
	input  sftx_pkg::q_stat_t q_stat,
	output logic              push,
	output sftx_pkg::job_t    job
);
	import sftx_pkg::*;

	logic [12:0] rem_q;
	logic [7:0]  left_q;
	logic        last_q;
	logic [7:0]  xor_q;
	logic        active_q;

	logic [12:0] rem_d;
	logic [7:0]  left_d;
	logic        last_d;
	logic [7:0]  xor_d;
	logic        active_d;

	logic        accept;
	logic        produce;
	logic        seg_go;
	logic [12:0] len_sat;
	logic [12:0] seg_src;
	logic [7:0]  xr;
	logic [7:0]  nl;
	seg_t        s;

	assign req_stall = q_stat.full;
	assign accept    = req_valid && !q_stat.full;
	assign push      = accept && produce;

	assign len_sat = (msg_length > MAX_MESSAGE) ? MAX_MESSAGE : msg_length;
	assign seg_src = (action == ACT_BEGIN) ? len_sat : rem_q;
	assign s       = start_seg(seg_src);
	assign xr      = xor_q ^ data_byte;
	assign nl      = left_q - 8'd1;

	always_comb begin
		rem_d       = rem_q;
		left_d      = left_q;
		last_d      = last_q;
		xor_d       = xor_q;
		active_d    = active_q;
		produce     = 1'b0;
		seg_go      = 1'b0;
		job         = '0;
		job.data    = data_byte;
		job.fin_chk = NEWLINE_BYTE;
		case (action)
			ACT_BEGIN: begin
				produce    = 1'b1;
				job.len    = s.len;
				seg_go     = 1'b1;
			end
			ACT_DATA: begin
				if (active_q && left_q != 8'd0) begin
					produce      = 1'b1;
					job.has_data = 1'b1;
					if (nl != 8'd0) begin
						left_d = nl;
						xor_d  = xr;
					end else if (last_q) begin
						job.close   = 1'b1;
						job.fin_chk = block_check(xr ^ NEWLINE_BYTE);
						rem_d       = '0;
						left_d      = '0;
						last_d      = 1'b0;
						xor_d       = '0;
						active_d    = 1'b0;
					end else begin
						job.mid_chk = 1'b1;
						job.mid_val = block_check(xr);
						job.len     = s.len;
						seg_go      = 1'b1;
					end
				end
			end
			ACT_CTRL: begin
				produce     = 1'b1;
				job.is_ctrl = 1'b1;
				job.len     = ctrl_code(control_kind);
			end
			default: begin
			end
		endcase
		if (seg_go) begin
			xor_d = '0;
			if (s.last_seg && s.left == 8'd0) begin
				job.close = 1'b1;
				rem_d     = '0;
				left_d    = '0;
				last_d    = 1'b0;
				active_d  = 1'b0;
			end else begin
				rem_d    = s.rem;
				left_d   = s.left;
				last_d   = s.last_seg;
				active_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			left_q   <= '0;
			last_q   <= 1'b0;
			xor_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			rem_q    <= rem_d;
			left_q   <= left_d;
			last_q   <= last_d;
			xor_q    <= xor_d;
			active_q <= active_d;
		end
	end

endmodule

@@ hdl/sftx_queue.sv @@
module sftx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sftx_pkg::job_t    job_in,
	input  logic              pop,
	output sftx_pkg::job_t    job_out,
	output sftx_pkg::q_stat_t q_stat
);
	import sftx_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign job_out      = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == QCNT_FULL);
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ hdl/sftx_back.sv @@
module sftx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sftx_pkg::job_t    head,
	input  sftx_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              tx_valid,
	input  logic              tx_stall,
	output logic [7:0]        line_byte,
	output logic              frame_end,
	output logic              run_last
);
	import sftx_pkg::*;

	step_t      step_q;
	logic       started_q;
	logic       tx_valid_q;
	logic [7:0] line_byte_q;
	logic       frame_end_q;
	logic       run_last_q;

	step_t      first_step;
	step_t      cur_step;
	step_t      nxt_step;
	logic       last;
	logic       emit;
	logic [7:0] byte_d;
	logic       end_d;

	always_comb begin
		if (head.is_ctrl)
			first_step = ST_CSYN;
		else if (head.has_data)
			first_step = ST_DATA;
		else
			first_step = ST_SYN;
	end

	assign cur_step = started_q ? step_q : first_step;

	// next step
	always_comb begin
		nxt_step = ST_SYN;
		last     = 1'b0;
		case (cur_step)
			ST_DATA: begin
				if (head.mid_chk)
					nxt_step = ST_MIDCHK;
				else if (head.close)
					nxt_step = ST_NL;
				else
					last = 1'b1;
			end
			ST_MIDCHK: nxt_step = ST_SYN;
			ST_SYN:    nxt_step = ST_TYPE;
			ST_TYPE:   nxt_step = ST_STX;
			ST_STX:    nxt_step = ST_DIR;
			ST_DIR:    nxt_step = ST_LEN;
			ST_LEN: begin
				if (head.close)
					nxt_step = ST_NL;
				else
					last = 1'b1;
			end
			ST_NL:     nxt_step = ST_FINCHK;
			ST_FINCHK: last = 1'b1;
			ST_CSYN:   nxt_step = ST_CTYPE;
			ST_CTYPE:  nxt_step = ST_CODE;
			ST_CODE:   nxt_step = ST_CDIR;
			ST_CDIR:   last = 1'b1;
			default:   last = 1'b1;
		endcase
	end

	// byte for the current step
	always_comb begin
		byte_d = SYN_BYTE;
		end_d  = 1'b0;
		case (cur_step)
			ST_DATA:   byte_d = head.data;
			ST_MIDCHK: begin
				byte_d = head.mid_val;
				end_d  = 1'b1;
			end
			ST_SYN:    byte_d = SYN_BYTE;
			ST_TYPE:   byte_d = TYPE_BYTE;
			ST_STX:    byte_d = STX_BYTE;
			ST_DIR:    byte_d = DIR_BYTE;
			ST_LEN:    byte_d = head.len;
			ST_NL:     byte_d = NEWLINE_BYTE;
			ST_FINCHK: begin
				byte_d = head.fin_chk;
				end_d  = 1'b1;
			end
			ST_CSYN:   byte_d = SYN_BYTE;
			ST_CTYPE:  byte_d = TYPE_BYTE;
			ST_CODE:   byte_d = head.len;
			ST_CDIR: begin
				byte_d = DIR_BYTE;
				end_d  = 1'b1;
			end
			default:   byte_d = SYN_BYTE;
		endcase
	end

	assign emit = !q_stat.empty && (!tx_valid_q || !tx_stall);
	assign pop  = emit && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_SYN;
			started_q  <= 1'b0;
			tx_valid_q <= 1'b0;
		end else begin
			tx_valid_q <= emit || (tx_valid_q && tx_stall);
			if (emit) begin
				started_q <= !last;
				step_q    <= nxt_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			line_byte_q <= byte_d;
			frame_end_q <= end_d;
			run_last_q  <= last;
		end
	end

	assign tx_valid  = tx_valid_q;
	assign line_byte = line_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule
